// ===== rtl/core/i2c_master_write_sequencer_macros.svh =====
// assertion macros for the i2c master write sequencer
// used by the controller and datapath modules; no other dependencies
`ifndef I2C_MASTER_WRITE_SEQUENCER_MACROS_SVH
`define I2C_MASTER_WRITE_SEQUENCER_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, disabled while reset is asserted
`define SEQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, disabled while reset is asserted
`define SEQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SEQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SEQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/i2cmws_pkg.sv =====
// shared types and constants of the i2c master write sequencer
// no dependencies
`timescale 1ns / 1ps
package i2cmws_pkg;

  localparam int MAX_BYTES = 128;
  localparam int ADDR_W    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int BC_W      = 7;

  // input modes
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_BEGIN  = 2'd1;
  localparam logic [1:0] MODE_STATUS = 2'd2;

  // bus actions
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_TX    = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  // result codes
  localparam logic [2:0] RC_OK        = 3'd0;
  localparam logic [2:0] RC_NO_START  = 3'd1;
  localparam logic [2:0] RC_ADDR_NACK = 3'd2;
  localparam logic [2:0] RC_DATA_NACK = 3'd3;
  localparam logic [2:0] RC_REG_NACK  = 3'd4;

  // bus status codes
  localparam logic [7:0] STATUS_MASK  = 8'hF8;
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_ADDR_ACK  = 8'h18;
  localparam logic [7:0] ST_DATA_ACK  = 8'h28;
  localparam logic [7:0] WR_ADDR_MASK = 8'hFE;

  typedef enum logic [1:0] {
    TX_ZERO    = 2'd0,
    TX_SLAVE   = 2'd1,
    TX_REG     = 2'd2,
    TX_PAYLOAD = 2'd3
  } tx_sel_t;

  // controller to datapath
  typedef struct packed {
    logic       take;
    logic       mem_write;
    logic       begin_txn;
    logic       sent_inc;
    logic       out_load;
    logic [1:0] action;
    tx_sel_t    tx_sel;
    logic       finished;
    logic [2:0] code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic       st_start_ok;
    logic       st_addr_ok;
    logic       st_data_ok;
    logic       skip;
    logic       more_data;
    logic       out_busy;
  } sts_t;

endpackage

// ===== rtl/core/i2cmws_datapath.sv =====
// datapath: item registers, payload buffer, latched transfer fields, result register
// depends on i2cmws_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "i2c_master_write_sequencer_macros.svh"
module i2cmws_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  i2cmws_pkg::cmd_t   cmd,
  output i2cmws_pkg::sts_t   sts,
  input  logic [1:0]         in_mode,
  input  logic [7:0]         in_payload_byte,
  input  logic [7:0]         in_slave_address,
  input  logic [7:0]         in_register_address,
  input  logic               in_skip_register,
  input  logic [6:0]         in_byte_count,
  input  logic [7:0]         in_bus_status,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_action,
  output logic [7:0]         out_tx_byte,
  output logic               out_finished,
  output logic [2:0]         out_result_code
);
  import i2cmws_pkg::*;

  // registered input item
  logic [1:0]      mode_r;
  logic [7:0]      payload_r;
  logic [7:0]      slave_in_r;
  logic [7:0]      reg_in_r;
  logic            skip_in_r;
  logic [BC_W-1:0] count_in_r;
  logic [7:0]      status_r;

  // transaction state
  logic [ADDR_W-1:0] load_ptr_r, load_ptr_nxt;
  logic [CNT_W-1:0]  sent_r, sent_nxt;
  logic [7:0]        slave_r;
  logic [7:0]        reg_r;
  logic              skip_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_sat;
  logic [BC_W:0]     bc_ext;

  logic [7:0] mem [MAX_BYTES];
  logic [7:0] rd_data_r;

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] act_r;
  logic [7:0] tx_r;
  logic [7:0] tx_mux;
  logic       fin_r;
  logic [2:0] code_r;
  logic [7:0] status_masked;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mode_r     <= in_mode;
      payload_r  <= in_payload_byte;
      slave_in_r <= in_slave_address;
      reg_in_r   <= in_register_address;
      skip_in_r  <= in_skip_register;
      count_in_r <= in_byte_count;
      status_r   <= in_bus_status;
    end
  end

  always_comb begin
    bc_ext = {1'b0, count_in_r};
    if (bc_ext > (BC_W + 1)'(MAX_BYTES)) begin
      cnt_sat = CNT_W'(MAX_BYTES);
    end else begin
      cnt_sat = CNT_W'(bc_ext);
    end
  end

  always_comb begin
    load_ptr_nxt = load_ptr_r;
    sent_nxt     = sent_r;
    if (cmd.mem_write) begin
      if (load_ptr_r == ADDR_W'(MAX_BYTES - 1)) begin
        load_ptr_nxt = '0;
      end else begin
        load_ptr_nxt = load_ptr_r + 1'b1;
      end
    end
    if (cmd.begin_txn) begin
      load_ptr_nxt = '0;
      sent_nxt     = '0;
    end else if (cmd.sent_inc) begin
      sent_nxt = sent_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_ptr_r <= '0;
      sent_r     <= '0;
      slave_r    <= '0;
      reg_r      <= '0;
      skip_r     <= 1'b0;
      cnt_r      <= '0;
    end else begin
      load_ptr_r <= load_ptr_nxt;
      sent_r     <= sent_nxt;
      if (cmd.begin_txn) begin
        slave_r <= slave_in_r;
        reg_r   <= reg_in_r;
        skip_r  <= skip_in_r;
        cnt_r   <= cnt_sat;
      end
    end
  end

  // payload buffer, read address follows the next sent count
  always_ff @(posedge clk) begin
    if (cmd.mem_write) begin
      mem[load_ptr_r] <= payload_r;
    end
    rd_data_r <= mem[sent_nxt[ADDR_W-1:0]];
  end

  assign status_masked = status_r & STATUS_MASK;

  always_comb begin
    sts.mode        = mode_r;
    sts.st_start_ok = (status_masked == ST_START);
    sts.st_addr_ok  = (status_masked == ST_ADDR_ACK);
    sts.st_data_ok  = (status_masked == ST_DATA_ACK);
    sts.skip        = skip_r;
    sts.more_data   = (sent_r < cnt_r);
    sts.out_busy    = out_valid_r && out_stall;
  end

  always_comb begin
    unique case (cmd.tx_sel)
      TX_SLAVE:   tx_mux = slave_r & WR_ADDR_MASK;
      TX_REG:     tx_mux = reg_r;
      TX_PAYLOAD: tx_mux = rd_data_r;
      default:    tx_mux = 8'h00;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      act_r  <= cmd.action;
      tx_r   <= tx_mux;
      fin_r  <= cmd.finished;
      code_r <= cmd.code;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_action      = act_r;
  assign out_tx_byte     = tx_r;
  assign out_finished    = fin_r;
  assign out_result_code = code_r;

  // never send more bytes than were latched
  `SEQ_ASSERT_IMP(a_sent_within_count, clk, rst_n, 1'b1, sent_r <= cnt_r)
  // a stalled result stays offered
  `SEQ_ASSERT_NXT(a_valid_held, clk, rst_n, out_valid_r && out_stall, out_valid_r)
  // a stalled result keeps its byte
  `SEQ_ASSERT_NXT(a_tx_held, clk, rst_n, out_valid_r && out_stall, $stable(tx_r))

endmodule

// ===== rtl/core/i2cmws_controller.sv =====
// controller: item sequencing and bus transaction phase state machines
// depends on i2cmws_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "i2c_master_write_sequencer_macros.svh"
module i2cmws_controller (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  i2cmws_pkg::sts_t sts,
  output i2cmws_pkg::cmd_t cmd
);
  import i2cmws_pkg::*;

  typedef enum logic [2:0] {
    S_TAKE   = 3'b001,
    S_DECIDE = 3'b010,
    S_EMIT   = 3'b100
  } seq_t;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_START = 5'b00010,
    PH_ADDR  = 5'b00100,
    PH_REG   = 5'b01000,
    PH_DATA  = 5'b10000
  } phase_t;

  seq_t   state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   idle;

  assign idle     = (phase_r == PH_IDLE);
  assign in_stall = (state_r != S_TAKE);

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    cmd          = '0;
    cmd.action   = ACT_START;
    cmd.tx_sel   = TX_ZERO;
    cmd.code     = RC_OK;
    unique case (state_r)
      S_TAKE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.mem_write = (sts.mode == MODE_LOAD) && idle;
        cmd.begin_txn = (sts.mode == MODE_BEGIN) && idle;
        cmd.sent_inc  = (sts.mode == MODE_STATUS) && (phase_r == PH_DATA) && sts.st_data_ok;
        if (((sts.mode == MODE_BEGIN) && idle) || ((sts.mode == MODE_STATUS) && !idle)) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_TAKE;
        end
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_TAKE;
          if (sts.mode == MODE_BEGIN) begin
            cmd.action = ACT_START;
            phase_nxt  = PH_START;
          end else begin
            unique case (phase_r)
              PH_START: begin
                if (!sts.st_start_ok) begin
                  cmd.action   = ACT_STOP;
                  cmd.finished = 1'b1;
                  cmd.code     = RC_NO_START;
                  phase_nxt    = PH_IDLE;
                end else begin
                  cmd.action = ACT_TX;
                  cmd.tx_sel = TX_SLAVE;
                  phase_nxt  = PH_ADDR;
                end
              end
              PH_ADDR: begin
                if (!sts.st_addr_ok) begin
                  cmd.action   = ACT_STOP;
                  cmd.finished = 1'b1;
                  cmd.code     = RC_ADDR_NACK;
                  phase_nxt    = PH_IDLE;
                end else if (!sts.skip) begin
                  cmd.action = ACT_TX;
                  cmd.tx_sel = TX_REG;
                  phase_nxt  = PH_REG;
                end else if (sts.more_data) begin
                  cmd.action = ACT_TX;
                  cmd.tx_sel = TX_PAYLOAD;
                  phase_nxt  = PH_DATA;
                end else begin
                  cmd.action   = ACT_STOP;
                  cmd.finished = 1'b1;
                  phase_nxt    = PH_IDLE;
                end
              end
              PH_REG, PH_DATA: begin
                if (!sts.st_data_ok) begin
                  cmd.action   = ACT_STOP;
                  cmd.finished = 1'b1;
                  cmd.code     = (phase_r == PH_REG) ? RC_REG_NACK : RC_DATA_NACK;
                  phase_nxt    = PH_IDLE;
                end else if (sts.more_data) begin
                  cmd.action = ACT_TX;
                  cmd.tx_sel = TX_PAYLOAD;
                  phase_nxt  = PH_DATA;
                end else begin
                  cmd.action   = ACT_STOP;
                  cmd.finished = 1'b1;
                  phase_nxt    = PH_IDLE;
                end
              end
              default: begin
                phase_nxt = PH_IDLE;
              end
            endcase
          end
        end
      end
      default: begin
        state_nxt = S_TAKE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_TAKE;
      phase_r <= PH_IDLE;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  // result register is only loaded when it can take a new transfer
  `SEQ_ASSERT_IMP(a_load_when_free, clk, rst_n, cmd.out_load, !sts.out_busy)
  // a stop with finished always returns the bus phase to idle
  `SEQ_ASSERT_NXT(a_stop_goes_idle, clk, rst_n, cmd.out_load && cmd.finished, phase_r == PH_IDLE)
  // an accepted item is always evaluated in the following cycle
  `SEQ_ASSERT_NXT(a_take_then_decide, clk, rst_n, cmd.take, state_r == S_DECIDE)

endmodule

// ===== rtl/core/i2c_master_write_sequencer.sv =====
// steps of the sequencing state machine per input item: take, evaluate, emit;
//   items that give no result return to take after evaluate; emit waits while the
//   output is stalled, then loads the result register; no input is taken in between
// the next input is taken while a result still waits in the output register
// reset: synchronous active-low, clears phase, pointers, latched fields and output valid;
//   the payload buffer is not cleared and holds nothing defined until loaded
`timescale 1ns / 1ps
module i2c_master_write_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_payload_byte,
  input  logic [7:0] in_slave_address,
  input  logic [7:0] in_register_address,
  input  logic       in_skip_register,
  input  logic [6:0] in_byte_count,
  input  logic [7:0] in_bus_status,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_action,
  output logic [7:0] out_tx_byte,
  output logic       out_finished,
  output logic [2:0] out_result_code
);
  import i2cmws_pkg::*;

  // command and status between the two halves
  cmd_t cmd;
  sts_t sts;

  // controller: decides each step of the bus write and when to take the next transfer
  i2cmws_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: payload buffer, latched address fields, byte counters, result register
  i2cmws_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_mode             (in_mode),
    .in_payload_byte     (in_payload_byte),
    .in_slave_address    (in_slave_address),
    .in_register_address (in_register_address),
    .in_skip_register    (in_skip_register),
    .in_byte_count       (in_byte_count),
    .in_bus_status       (in_bus_status),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_action          (out_action),
    .out_tx_byte         (out_tx_byte),
    .out_finished        (out_finished),
    .out_result_code     (out_result_code)
  );

endmodule
